@@ src/stop_and_wait_connection_table_assert.svh @@
// Assertion helpers for the RTL.
`ifndef STOP_AND_WAIT_CONNECTION_TABLE_ASSERT_SVH
`define STOP_AND_WAIT_CONNECTION_TABLE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define SWCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SWCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/swct_pkg.sv @@
package swct_pkg;

    localparam int MAX_CONNS_DEF    = 16;
    localparam int OUTBOX_DEPTH_DEF = 16;
    localparam int MAX_RESULTS      = 48;
    localparam int PEND_W           = 9;
    localparam logic [7:0] EPOCH_LIMIT_RST = 8'd5;

    typedef enum logic [1:0] {
        KIND_PACKET = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_CLOSE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_ACK        = 3'd0,
        ACT_SEND       = 3'd1,
        ACT_DELIVER    = 3'd2,
        ACT_DISCONNECT = 3'd3,
        ACT_WRITE_OK   = 3'd4,
        ACT_REJECT     = 3'd5
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [4:0]  conn;
        logic [31:0] seq;
    } result_t;

    typedef struct packed {
        logic [47:0]       host;
        logic [31:0]       sent;
        logic [31:0]       recv;
        logic [31:0]       acked;
        logic [PEND_W-1:0] pend;
        logic [7:0]        idle;
        logic [31:0]       mark;
    } entry_t;

endpackage

@@ src/swct_result_out.sv @@
module swct_result_out
    import swct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_res,
    output logic        push_ok,
    input  logic        flush,
    output logic        flush_ok,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_conn[4:0], out_seq[36:5], zero pad
    output logic [2:0]  m_axis_tuser,   // action[2:0]
    output logic        m_axis_tlast    // last
);

    logic    out_valid_reg;
    logic    hold_valid_reg;
    logic [5:0] cnt_reg;
    result_t hold_reg;
    result_t out_reg;
    logic    out_last_reg;
    logic    out_free;
    logic    capped;
    logic    do_push;
    logic    do_flush;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign capped   = cnt_reg >= 6'(MAX_RESULTS);
    assign push_ok  = capped || !hold_valid_reg || out_free;
    assign flush_ok = !hold_valid_reg || out_free;
    assign do_push  = push && push_ok && !capped;
    assign do_flush = !push && flush && flush_ok;

    // Hold back one result so the final one can be marked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if ((do_push || do_flush) && hold_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_push)
            begin
                hold_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + 6'd1;
            end
            else if (do_flush)
            begin
                hold_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            hold_reg <= push_res;
            if (hold_valid_reg)
            begin
                out_reg      <= hold_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (do_flush && hold_valid_reg)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.seq, out_reg.conn};
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ src/stop_and_wait_connection_table.sv @@
// Stop-and-wait connection table, server side.
// Input items arrive on s_axis: tuser carries the kind (packet, epoch tick,
// application write, close), tdata the host address, connection id, sequence
// number and payload flag. Each item yields zero or more results on m_axis:
// tuser is the action, tdata the connection and sequence number, tlast marks
// the final result of an item. epoch_limit is written via cfg_wr_en and
// cfg_wr_data; a write of zero is dropped. The user must write it only while
// the block is idle, which the block itself does not enforce. One item is
// worked at a time by a sequencer around an entry memory with one write port,
// a registered read port and a shared datapath. A connect request scans the
// table entry by entry before it creates one; an epoch tick visits every slot
// and works each live connection. Results pass through a one-deep hold stage
// and an output register, so the final result is known before it leaves; a
// stalled receiver stalls the sequencer at the next result. Reset clears valid
// and connected bits, sets the next id to one and epoch_limit to 5; entry
// data is written on creation.
module stop_and_wait_connection_table
    import swct_pkg::*;
#(
    parameter int MAX_CONNS    = MAX_CONNS_DEF,
    parameter int OUTBOX_DEPTH = OUTBOX_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // host_addr[47:0], conn_id[52:48], seq_num[84:53],
                                        // has_payload[85], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_conn[4:0], out_seq[36:5], zero pad
    output logic [2:0]  m_axis_tuser,   // action[2:0]
    output logic        m_axis_tlast,   // last
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

`include "stop_and_wait_connection_table_assert.svh"

    localparam int IW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
    localparam int NW = $clog2(MAX_CONNS + 2);

    typedef enum logic [4:0] {
        ST_IDLE, ST_REJ, ST_SCAN_RD, ST_SCAN_CMP, ST_CREATE, ST_RD, ST_LOAD,
        ST_EXEC, ST_ACC, ST_POLL, ST_DATA_ACK, ST_WB, ST_TICK_CHK, ST_T_ACK,
        ST_T_HEAD, ST_T_IDLE, ST_FINISH
    } state_t;

    state_t         state_reg;
    logic [MAX_CONNS-1:0] valid_reg;
    logic [MAX_CONNS-1:0] conn_reg;
    logic [NW-1:0]  next_id_reg;
    logic [IW-1:0]  idx_reg;
    logic [7:0]     epoch_limit_reg;

    kind_t          kind_reg;
    logic [47:0]    host_reg;
    logic [4:0]     id_reg;
    logic [31:0]    seq_reg;
    logic           pay_reg;
    entry_t         rec_reg;
    entry_t         rd_data_reg;
    entry_t         mem [MAX_CONNS];

    kind_t          in_kind;
    logic [47:0]    in_host;
    logic [4:0]     in_id;
    logic [31:0]    in_seq;
    logic           in_pay;
    logic           in_known;
    logic [IW-1:0]  in_slot;

    logic [31:0]    head;
    logic           poll_hit;
    logic           full;
    logic           data_hit;
    logic [7:0]     idle_new;
    logic           disc;
    logic           next_ok;
    logic [IW-1:0]  new_slot;
    logic           last_idx;
    logic [4:0]     idx_conn;

    logic           emit_req;
    result_t        emit_res;
    logic           push_ok;
    logic           flush_ok;
    logic           go;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    entry_t         mem_wdata;

    assign in_kind = kind_t'(s_axis_tuser);
    assign in_host = s_axis_tdata[47:0];
    assign in_id   = s_axis_tdata[52:48];
    assign in_seq  = s_axis_tdata[84:53];
    assign in_pay  = s_axis_tdata[85];
    assign in_slot = IW'(in_id - 5'd1);

    always_comb
    begin
        in_known = 1'b0;
        if (in_id != 5'd0 && 32'(in_id) <= 32'(MAX_CONNS))
        begin
            in_known = valid_reg[in_slot];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Shared datapath on the working entry.
    assign head     = rec_reg.sent - 32'(rec_reg.pend) + 32'd1;
    assign poll_hit = conn_reg[idx_reg] && rec_reg.pend != '0 &&
                      (rec_reg.acked + 32'd1) > rec_reg.mark;
    assign full     = 32'(rec_reg.pend) >= 32'(OUTBOX_DEPTH);
    assign data_hit = seq_reg == (rec_reg.recv + 32'd1);
    assign idle_new = (rec_reg.idle == 8'hFF) ? rec_reg.idle : rec_reg.idle + 8'd1;
    assign disc     = idle_new >= epoch_limit_reg;
    assign next_ok  = 32'(next_id_reg) <= 32'(MAX_CONNS);
    assign new_slot = IW'(next_id_reg - NW'(1));
    assign last_idx = idx_reg == IW'(MAX_CONNS - 1);
    assign idx_conn = 5'(32'(idx_reg) + 32'd1);

    // Result produced in the current state, if any.
    always_comb
    begin
        emit_req = 1'b0;
        emit_res = '{action: ACT_ACK, conn: '0, seq: '0};
        unique case (state_reg)
            ST_REJ:
            begin
                emit_req = 1'b1;
                emit_res = '{action: ACT_REJECT, conn: id_reg, seq: '0};
            end
            ST_CREATE:
            begin
                emit_req = 1'b1;
                if (next_ok)
                begin
                    emit_res = '{action: ACT_ACK, conn: 5'(next_id_reg), seq: '0};
                end
                else
                begin
                    emit_res = '{action: ACT_REJECT, conn: '0, seq: '0};
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_WRITE)
                begin
                    emit_req = full;
                    emit_res = '{action: ACT_REJECT, conn: id_reg, seq: '0};
                end
                else if (pay_reg)
                begin
                    emit_req = data_hit;
                    emit_res = '{action: ACT_DELIVER, conn: id_reg, seq: seq_reg};
                end
            end
            ST_ACC:
            begin
                emit_req = 1'b1;
                emit_res = '{action: ACT_WRITE_OK, conn: id_reg, seq: rec_reg.sent};
            end
            ST_POLL:
            begin
                emit_req = poll_hit;
                emit_res = '{action: ACT_SEND, conn: id_reg, seq: head};
            end
            ST_DATA_ACK:
            begin
                emit_req = 1'b1;
                emit_res = '{action: ACT_ACK, conn: id_reg, seq: seq_reg};
            end
            ST_T_ACK:
            begin
                emit_req = 1'b1;
                emit_res = '{action: ACT_ACK, conn: idx_conn, seq: rec_reg.recv};
            end
            ST_T_HEAD:
            begin
                emit_req = rec_reg.pend != '0;
                emit_res = '{action: ACT_SEND, conn: idx_conn, seq: head};
            end
            ST_T_IDLE:
            begin
                emit_req = disc;
                emit_res = '{action: ACT_DISCONNECT, conn: idx_conn, seq: '0};
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign go = !emit_req || push_ok;

    // Entry memory write: creation, write-back, tick update.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rec_reg;
        if (state_reg == ST_CREATE)
        begin
            mem_we    = go && next_ok;
            mem_waddr = new_slot;
            mem_wdata = '{host: host_reg, default: '0};
        end
        else if (state_reg == ST_WB)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_T_IDLE)
        begin
            mem_we         = go;
            mem_wdata.idle = idle_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_limit_reg <= EPOCH_LIMIT_RST;
        end
        else if (cfg_wr_en && cfg_wr_data != 8'd0)
        begin
            epoch_limit_reg <= cfg_wr_data;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            conn_reg    <= '0;
            next_id_reg <= NW'(1);
            idx_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        unique case (in_kind)
                            KIND_PACKET:
                            begin
                                if (in_id == 5'd0)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= (in_seq == 32'd0 && !in_pay) ?
                                                 ST_SCAN_RD : ST_FINISH;
                                end
                                else
                                begin
                                    idx_reg   <= in_slot;
                                    state_reg <= in_known ? ST_RD : ST_FINISH;
                                end
                            end
                            KIND_TICK:
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_TICK_CHK;
                            end
                            KIND_WRITE:
                            begin
                                idx_reg   <= in_slot;
                                state_reg <= in_known ? ST_RD : ST_REJ;
                            end
                            KIND_CLOSE:
                            begin
                                if (in_id == 5'd0)
                                begin
                                    valid_reg   <= '0;
                                    conn_reg    <= '0;
                                    next_id_reg <= NW'(1);
                                end
                                else if (in_known)
                                begin
                                    valid_reg[in_slot] <= 1'b0;
                                    conn_reg[in_slot]  <= 1'b0;
                                end
                                state_reg <= ST_FINISH;
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_REJ:
                begin
                    if (go)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP:
                begin
                    if (valid_reg[idx_reg] && rd_data_reg.host == host_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (last_idx)
                    begin
                        state_reg <= ST_CREATE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_CREATE:
                begin
                    if (go)
                    begin
                        if (next_ok)
                        begin
                            valid_reg[new_slot] <= 1'b1;
                            conn_reg[new_slot]  <= 1'b1;
                            next_id_reg         <= next_id_reg + NW'(1);
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= (kind_reg == KIND_TICK) ? ST_T_ACK : ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (go)
                    begin
                        if (kind_reg == KIND_WRITE)
                        begin
                            state_reg <= full ? ST_FINISH : ST_ACC;
                        end
                        else if (pay_reg)
                        begin
                            state_reg <= data_hit ? ST_DATA_ACK : ST_WB;
                        end
                        else
                        begin
                            state_reg <= ST_POLL;
                        end
                    end
                end
                ST_ACC:
                begin
                    if (go)
                    begin
                        state_reg <= ST_POLL;
                    end
                end
                ST_POLL:
                begin
                    if (go)
                    begin
                        state_reg <= ST_WB;
                    end
                end
                ST_DATA_ACK:
                begin
                    if (go)
                    begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_TICK_CHK:
                begin
                    if (valid_reg[idx_reg] && conn_reg[idx_reg])
                    begin
                        state_reg <= ST_RD;
                    end
                    else if (last_idx)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_T_ACK:
                begin
                    if (go)
                    begin
                        state_reg <= ST_T_HEAD;
                    end
                end
                ST_T_HEAD:
                begin
                    if (go)
                    begin
                        state_reg <= ST_T_IDLE;
                    end
                end
                ST_T_IDLE:
                begin
                    if (go)
                    begin
                        if (disc)
                        begin
                            conn_reg[idx_reg] <= 1'b0;
                        end
                        if (last_idx)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= ST_TICK_CHK;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (flush_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item fields and working entry.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            kind_reg <= in_kind;
            host_reg <= in_host;
            id_reg   <= in_id;
            seq_reg  <= in_seq;
            pay_reg  <= in_pay;
        end
        if (state_reg == ST_LOAD)
        begin
            rec_reg <= rd_data_reg;
        end
        else if (state_reg == ST_EXEC && go)
        begin
            if (kind_reg == KIND_WRITE)
            begin
                if (!full)
                begin
                    rec_reg.sent <= rec_reg.sent + 32'd1;
                    rec_reg.pend <= rec_reg.pend + PEND_W'(1);
                end
            end
            else
            begin
                rec_reg.idle <= 8'd0;
                if (pay_reg)
                begin
                    if (data_hit)
                    begin
                        rec_reg.recv <= seq_reg;
                    end
                end
                else
                begin
                    if (seq_reg == rec_reg.acked + 32'd1)
                    begin
                        rec_reg.acked <= seq_reg;
                    end
                    if (rec_reg.pend != '0 && seq_reg == head)
                    begin
                        rec_reg.pend <= rec_reg.pend - PEND_W'(1);
                    end
                end
            end
        end
        else if (state_reg == ST_POLL && go && poll_hit)
        begin
            rec_reg.mark <= head;
        end
    end

    swct_result_out u_result_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (emit_req),
        .push_res      (emit_res),
        .push_ok       (push_ok),
        .flush         (state_reg == ST_FINISH),
        .flush_ok      (flush_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `SWCT_ASSERT_ALWAYS(a_conn_implies_valid, clk, ((conn_reg & ~valid_reg) == '0),
        "connected entry is not valid")
    `SWCT_ASSERT(a_next_id_range, clk, rst_n,
        (next_id_reg >= NW'(1) && 32'(next_id_reg) <= 32'(MAX_CONNS) + 32'd1),
        "next id out of range")
    `SWCT_ASSERT(a_busy_after_accept, clk, rst_n,
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE),
        "sequencer idle right after accepting an item")

endmodule

@@ verif/tb_stop_and_wait_connection_table.sv @@
module tb_stop_and_wait_connection_table;
    import swct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCONN = MAX_CONNS_DEF;
    localparam int DEPTH = OUTBOX_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        action_t     action;
        logic [4:0]  conn;
        logic [31:0] seq;
        logic        last;
    } arq_result_t;

    // Scoreboard: holds its own copy of the connection table and a queue of
    // results that the table is expected to produce.
    class arq_scoreboard;
        logic [7:0]  epoch_limit;
        bit          valid_q[NCONN];
        bit          conn_q[NCONN];
        logic [47:0] host_q[NCONN];
        logic [31:0] sent_q[NCONN];
        logic [31:0] recv_q[NCONN];
        logic [31:0] acked_q[NCONN];
        int          pend_q[NCONN];
        int          idle_q[NCONN];
        logic [31:0] mark_q[NCONN];
        int          next_id;
        arq_result_t pending_results[$];
        int          errors;

        function new();
            epoch_limit = EPOCH_LIMIT_RST;
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int i = 0; i < NCONN; i++)
            begin
                valid_q[i] = 0; conn_q[i] = 0; host_q[i] = '0; sent_q[i] = '0;
                recv_q[i] = '0; acked_q[i] = '0; pend_q[i] = 0; idle_q[i] = 0;
                mark_q[i] = '0;
            end
            next_id = 1;
        endfunction

        function void set_limit(logic [7:0] v);
            if (v != 0)
                epoch_limit = v;
        endfunction

        function void push(action_t a, int c, logic [31:0] s);
            arq_result_t r;
            r.action = a; r.conn = c[4:0]; r.seq = s; r.last = 0;
            pending_results.push_back(r);
        endfunction

        function logic [31:0] head_seq(int s);
            return sent_q[s] - pend_q[s] + 1;
        endfunction

        function void run_poll(int s);
            logic [31:0] h;
            if (!conn_q[s] || pend_q[s] == 0)
                return;
            if (acked_q[s] + 32'd1 > mark_q[s])
            begin
                h = head_seq(s);
                push(ACT_SEND, s + 1, h);
                mark_q[s] = h;
            end
        endfunction

        // Note an accepted input item and append the results it causes.
        function void note_input(kind_t kind, logic [47:0] host, logic [4:0] id,
                                 logic [31:0] seq, logic pay);
            int  base;
            bit  known;
            bit  seen;
            int  s;
            base  = pending_results.size();
            known = id >= 1 && id <= NCONN && valid_q[id - 1];
            s     = known ? id - 1 : 0;
            case (kind)
                KIND_PACKET:
                begin
                    if (id == 0 && seq == 0 && !pay)
                    begin
                        seen = 0;
                        for (int i = 0; i < NCONN; i++)
                            if (valid_q[i] && host_q[i] == host)
                                seen = 1;
                        if (!seen)
                        begin
                            if (next_id <= NCONN)
                            begin
                                int n;
                                n = next_id - 1;
                                valid_q[n] = 1; conn_q[n] = 1; host_q[n] = host;
                                sent_q[n] = 0; recv_q[n] = 0; acked_q[n] = 0;
                                pend_q[n] = 0; idle_q[n] = 0; mark_q[n] = 0;
                                next_id++;
                                push(ACT_ACK, n + 1, 0);
                            end
                            else
                                push(ACT_REJECT, 0, 0);
                        end
                    end
                    else if (known)
                    begin
                        idle_q[s] = 0;
                        if (!pay)
                        begin
                            if (seq == acked_q[s] + 32'd1)
                                acked_q[s] = seq;
                            if (pend_q[s] > 0 && seq == head_seq(s))
                                pend_q[s]--;
                            run_poll(s);
                        end
                        else if (seq == recv_q[s] + 32'd1)
                        begin
                            recv_q[s] = seq;
                            push(ACT_DELIVER, id, seq);
                            push(ACT_ACK, id, seq);
                        end
                    end
                end
                KIND_TICK:
                begin
                    for (int i = 0; i < NCONN; i++)
                    begin
                        if (!valid_q[i] || !conn_q[i])
                            continue;
                        push(ACT_ACK, i + 1, recv_q[i]);
                        if (pend_q[i] > 0)
                            push(ACT_SEND, i + 1, head_seq(i));
                        if (idle_q[i] < 255)
                            idle_q[i]++;
                        if (idle_q[i] >= epoch_limit)
                        begin
                            conn_q[i] = 0;
                            push(ACT_DISCONNECT, i + 1, 0);
                        end
                    end
                end
                KIND_WRITE:
                begin
                    if (!known || pend_q[s] >= DEPTH)
                        push(ACT_REJECT, id, 0);
                    else
                    begin
                        sent_q[s]++;
                        pend_q[s]++;
                        push(ACT_WRITE_OK, id, sent_q[s]);
                        run_poll(s);
                    end
                end
                default:
                begin
                    if (id == 0)
                        clear_table();
                    else if (known)
                    begin
                        valid_q[s] = 0;
                        conn_q[s] = 0;
                    end
                end
            endcase
            if (pending_results.size() > base)
                pending_results[pending_results.size() - 1].last = 1;
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(logic [2:0] act, logic [4:0] c, logic [31:0] s,
                                   logic l);
            arq_result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result act=%0d conn=%0d seq=%0h last=%0b",
                         $time, act, c, s, l);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (act !== e.action)
            begin
                $display("%0t: action expected %0d actual %0d", $time, e.action, act);
                errors++;
            end
            if (c !== e.conn)
            begin
                $display("%0t: out_conn expected %0d actual %0d", $time, e.conn, c);
                errors++;
            end
            if (s !== e.seq)
            begin
                $display("%0t: out_seq expected %0h actual %0h", $time, e.seq, s);
                errors++;
            end
            if (l !== e.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    stop_and_wait_connection_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    arq_scoreboard table_model = new();

    // Host addresses the random part picks from, so that connect requests
    // repeat and known hosts get ignored.
    logic [47:0] host_pool[8];
    int          long_stall_req;
    int          idle_cycles;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stall pattern, runs without stalls, and on request
    // one long hold-off that fills the block and stalls its input.
    initial
    begin
        int mode;
        int hold;
        m_axis_tready = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall_req > 0)
            begin
                hold = long_stall_req;
                long_stall_req = 0;
                m_axis_tready <= 0;
                repeat (hold) @(posedge clk);
            end
            if ($urandom_range(0, 40) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check every result moved on the master side.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_result(m_axis_tuser, m_axis_tdata[4:0],
                                     m_axis_tdata[36:5], m_axis_tlast);

    // Watchdog: count cycles in which nothing moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until the handshake; the model notes it then.
    task automatic send_item(kind_t kind, logic [47:0] host, logic [4:0] id,
                             logic [31:0] seq, logic pay);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, pay, seq, id, host};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        table_model.note_input(kind, host, id, seq, pay);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Drain all expected results, then let the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (table_model.pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * NCONN * 6 + 20) @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] v);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        table_model.set_limit(v);
        cfg_wr_en   <= 0;
        @(posedge clk);
    endtask

    // One random item, mostly well-formed traffic against live connections.
    task automatic random_item();
        int          r;
        logic [4:0]  id;
        logic [31:0] seq;
        int          s;
        r  = $urandom_range(0, 99);
        id = 5'($urandom_range(1, NCONN));
        s  = id - 1;
        if (r < 14)
            send_item(KIND_PACKET, host_pool[$urandom_range(0, 7)], 0, 0, 0);
        else if (r < 34)
        begin
            // Ack: mostly the expected next number, sometimes stale or random.
            seq = table_model.acked_q[s] + 1;
            if ($urandom_range(0, 4) == 0)
                seq = table_model.head_seq(s);
            if ($urandom_range(0, 9) == 0)
                seq = $urandom;
            send_item(KIND_PACKET, host_pool[0], id, seq, 0);
        end
        else if (r < 52)
        begin
            seq = table_model.recv_q[s] + 1;
            if ($urandom_range(0, 5) == 0)
                seq = $urandom;
            send_item(KIND_PACKET, host_pool[0], id, seq, 1);
        end
        else if (r < 78)
            send_item(KIND_WRITE, '0, $urandom_range(0, 3) == 0 ?
                      5'($urandom_range(0, 31)) : id, 0, 0);
        else if (r < 86)
            send_item(KIND_TICK, '0, 0, 0, 0);
        else if (r < 90)
            send_item(KIND_CLOSE, '0, $urandom_range(0, 10) == 0 ? 5'd0 : id, 0, 0);
        else
            // Noise: random fields, bogus packets, unknown ids.
            send_item(KIND_PACKET, 48'({$urandom, $urandom}), 5'($urandom_range(0, 31)),
                      $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int burst;
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PACKET;
        cfg_wr_en     = 0;
        cfg_wr_data   = '0;
        long_stall_req = 0;
        idle_cycles   = 0;
        host_pool[0] = 48'hFFFF_FFFF_FFFF;
        host_pool[1] = 48'h0;
        for (int i = 2; i < 8; i++)
            host_pool[i] = 48'({$urandom, $urandom});
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: connects at the host extremes, duplicate connect,
        // writes past a full outbox, acks, data, bogus packets, ticks to
        // timeout, table full, close one and close all.
        write_limit(8'd2);
        send_item(KIND_PACKET, 48'h0, 0, 0, 0);
        send_item(KIND_PACKET, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        send_item(KIND_PACKET, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        send_item(KIND_PACKET, 48'h1234, 0, 32'hFFFF_FFFF, 1);
        send_item(KIND_PACKET, 48'h1234, 31, 32'hFFFF_FFFF, 1);
        for (int i = 0; i < DEPTH + 1; i++)
            send_item(KIND_WRITE, '0, 1, 0, 0);
        send_item(KIND_PACKET, '0, 1, 1, 0);
        send_item(KIND_PACKET, '0, 2, 1, 1);
        send_item(KIND_WRITE, '0, 9, 0, 0);
        send_item(KIND_TICK, '0, 0, 0, 0);
        send_item(KIND_TICK, '0, 0, 0, 0);
        send_item(KIND_WRITE, '0, 2, 0, 0);
        send_item(KIND_PACKET, '0, 2, 32'hFFFF_FFFF, 0);
        wait_drained();
        write_limit(8'd0);
        write_limit(8'd255);
        for (int i = 0; i < NCONN + 1; i++)
            send_item(KIND_PACKET, 48'h100 + i, 0, 0, 0);
        send_item(KIND_CLOSE, '0, 3, 0, 0);
        send_item(KIND_PACKET, 48'h102, 0, 0, 0);
        send_item(KIND_CLOSE, '0, 0, 0, 0);
        wait_drained();
        write_limit(8'd1);

        // Random part in phases with different epoch limits.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_item(KIND_CLOSE, '0, 0, 0, 0);
            for (int i = 0; i < 4; i++)
                send_item(KIND_PACKET, host_pool[i], 0, 0, 0);
            for (int n = 0; n < 72; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 72; b++, n++)
                begin
                    if (phase == 1 && n == 30)
                        long_stall_req = 400;
                    random_item();
                end
                if (phase == 2 && n > 36 && n < 48)
                    wait_drained();
                else if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
            wait_drained();
            case (phase)
                0: write_limit(8'd255);
                1: write_limit(8'($urandom_range(2, 6)));
                default: write_limit(8'd3);
            endcase
        end

        s_axis_tvalid <= 0;
        wait_drained();
        if (table_model.errors == 0 && table_model.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
